// File: sv/first_fit_heap_allocator_unit_assert.svh
// Assertion macros shared by the allocator RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define FFHA_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define FFHA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
// No dependencies.
package ffha_pkg;

	localparam int MAX_BLOCKS   = 64;
	localparam int IDX_W        = $clog2(MAX_BLOCKS);
	localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
	localparam int HEAP_BYTES   = 65536;
	localparam int HEADER_BYTES = 12;
	localparam int PAGE_BITS    = 12;
	localparam int CFG_IDX_W    = 1;

	localparam logic [15:0] HDR16       = 16'(HEADER_BYTES);
	localparam logic [7:0]  SPLIT_RESET = 8'd16;

	typedef struct packed {
		logic [15:0] offset;
		logic [15:0] payload;
		logic        in_use;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	localparam entry_t ENTRY0_RESET = '{
		offset:  16'd0,
		payload: 16'(HEAP_BYTES - HEADER_BYTES),
		in_use:  1'b0
	};

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NO_MEMORY = 2'd1,
		ST_IGNORED   = 2'd2,
		ST_UNKNOWN   = 2'd3
	} status_t;

	localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPLIT     = 1'd1;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_NEXT  = 6'b000100,
		S_SHIFT = 6'b001000,
		S_WRITE = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

endpackage

// File: sv/ffha_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/first_fit_heap_allocator_unit.sv
// Top level of the first-fit heap allocator: sequencer around the block table RAM.
// Depends on ffha_pkg, ffha_ram and first_fit_heap_allocator_unit_assert.svh.
//
//   channel   direction  handshake                  payload
//   cfg       in         cfg_we (no wait)           cfg_index, cfg_wdata
//   request   in         in_valid / in_ready        mode, request_bytes, address
//   result    out        out_valid / out_ready      result_address, status
//
// An item enters in the idle state, then the table is scanned entry by entry up to a hit
// or, after the last entry, a miss. A free then reads its right neighbour in S_NEXT.
// The table shift moves the entries behind the hit up or down (nothing moves when no split
// or merge needs it), followed by one or two table writes and the load of the output
// register; the single read port of the table RAM sets the pace of the scan and the shift.
// After reset entry zero reads as the whole heap through a valid flag; no clearing pass.
// A new request transfer is taken in the idle state even while a result waits.
// A finished result waits in the done state until the output register is free.
module first_fit_heap_allocator_unit
	import ffha_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 mode,
	input  logic [15:0]          request_bytes,
	input  logic [31:0]          address,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          result_address,
	output logic [1:0]           status
);

	`include "first_fit_heap_allocator_unit_assert.svh"

	state_t state_q;

	// Configuration and derived heap start.
	logic [31:0] base_q;
	logic [7:0]  thr_q;
	logic [31:0] hs_q;

	// The request being served.
	logic        mode_q;
	logic [16:0] size_q;
	logic [31:0] addr_q;

	// Table bookkeeping.
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] tot_nx_q;
	logic             e0v_q;
	logic             rd0_q;

	// Scan pipeline.
	logic [CNT_W-1:0] cnt_q;
	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;
	entry_t           prev_q;
	entry_t           hit_q;
	logic [IDX_W-1:0] k_q;
	logic             nxt_ok_q;

	// Shift pipeline.
	logic [IDX_W-1:0] src_q;
	logic [CNT_W-1:0] rem_q;
	logic             up_q;
	logic             two_q;
	logic             sv_s1;
	logic [IDX_W-1:0] dst_s1;

	// Final writes.
	logic             w1_en_q;
	logic [IDX_W-1:0] w1_addr_q;
	entry_t           w1_q;
	logic [IDX_W-1:0] w0_addr_q;
	entry_t           w0_q;

	// Pending result and output register.
	logic [31:0] res_addr_q;
	status_t     res_st_q;
	logic        out_valid_q;
	logic [31:0] out_addr_q;
	status_t     out_st_q;

	// RAM ports.
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             ent_rd;

	ffha_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_BLOCKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Until entry zero is first written in the table RAM, it
	// reads as the reset block that spans the whole heap.
	assign ent_rd = (rd0_q && !e0v_q) ? ENTRY0_RESET : entry_t'(ram_rdata);

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign result_address = out_addr_q;
	assign status         = out_st_q;

	// Scan decisions on the entry that has just come out of the RAM.
	logic        fits;
	logic [15:0] leftover;
	logic [8:0]  thr_lim;
	logic        can_split;
	logic        match;
	logic        hit;
	logic        miss;
	logic [31:0] grant;

	assign fits      = !ent_rd.in_use && ({1'b0, ent_rd.payload} >= size_q);
	assign leftover  = ent_rd.payload - size_q[15:0];
	assign thr_lim   = {1'b0, thr_q} + 9'(HEADER_BYTES);
	assign can_split = (leftover > {7'd0, thr_lim}) && (total_q < CNT_W'(MAX_BLOCKS));
	assign grant     = hs_q + {16'd0, ent_rd.offset} + 32'(HEADER_BYTES);
	assign match     = (grant == addr_q);
	assign hit       = v_s1 && (mode_q ? match : fits);
	assign miss      = !v_s1 && (cnt_q >= total_q);

	// Neighbour decisions for a free, taken in the cycle after the hit.
	logic prev_free;
	logic next_free;

	assign prev_free = (k_q != '0) && !prev_q.in_use;
	assign next_free = nxt_ok_q && !ent_rd.in_use;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = cnt_q[IDX_W-1:0];
		ram_we    = 1'b0;
		ram_waddr = w0_addr_q;
		ram_wdata = w0_q;
		case (state_q)
			S_SCAN: begin
				ram_re = (cnt_q < total_q);
			end
			S_SHIFT: begin
				ram_re    = (rem_q != '0);
				ram_raddr = src_q;
				ram_we    = sv_s1;
				ram_waddr = dst_s1;
				ram_wdata = ent_rd;
			end
			S_WRITE: begin
				ram_we    = 1'b1;
				ram_waddr = w1_en_q ? w1_addr_q : w0_addr_q;
				ram_wdata = w1_en_q ? w1_q : w0_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_q      <= '0;
			thr_q       <= SPLIT_RESET;
			hs_q        <= '0;
			total_q     <= CNT_W'(1);
			e0v_q       <= 1'b0;
			rd0_q       <= 1'b0;
			v_s1        <= 1'b0;
			sv_s1       <= 1'b0;
			w1_en_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// The heap start is the base rounded up to a page.
			hs_q <= {base_q[31:PAGE_BITS] + (32-PAGE_BITS)'(|base_q[PAGE_BITS-1:0]),
				PAGE_BITS'(0)};

			if (cfg_we) begin
				case (cfg_index)
					REG_HEAP_BASE: base_q <= cfg_wdata;
					REG_SPLIT:     thr_q  <= cfg_wdata[7:0];
					default: begin
					end
				endcase
			end

			if (ram_re) begin
				rd0_q <= (ram_raddr == '0);
			end
			if (ram_we && (ram_waddr == '0)) begin
				e0v_q <= 1'b1;
			end

			// The output register is loaded from the done state and emptied by a transfer.
			if ((state_q == S_DONE) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q <= mode;
						size_q <= ({1'b0, request_bytes} + 17'd3) & ~17'd3;
						addr_q <= address;
						cnt_q  <= '0;
						if (mode ? (address == '0) : (request_bytes == '0)) begin
							res_addr_q <= '0;
							res_st_q   <= ST_IGNORED;
							state_q    <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					v_s1 <= ram_re && !hit;
					if (ram_re) begin
						cnt_q  <= cnt_q + CNT_W'(1);
						idx_s1 <= cnt_q[IDX_W-1:0];
					end
					if (hit) begin
						k_q      <= idx_s1;
						hit_q    <= ent_rd;
						nxt_ok_q <= ({1'b0, idx_s1} + CNT_W'(1)) < total_q;
						w1_en_q  <= !mode_q && can_split;
						w0_addr_q <= idx_s1;
						up_q     <= 1'b1;
						two_q    <= 1'b0;
						res_addr_q <= mode_q ? 32'd0 : grant;
						res_st_q <= ST_DONE;
						if (mode_q) begin
							state_q <= S_NEXT;
						end else begin
							state_q    <= S_SHIFT;
							if (can_split) begin
								// Move the tail up by one, then write the split pair.
								w1_addr_q <= idx_s1 + IDX_W'(1);
								w1_q      <= '{offset: ent_rd.offset + HDR16 + size_q[15:0],
									payload: leftover - HDR16, in_use: 1'b0};
								w0_q      <= '{offset: ent_rd.offset, payload: size_q[15:0],
									in_use: 1'b1};
								tot_nx_q  <= total_q + CNT_W'(1);
								src_q     <= IDX_W'(total_q - CNT_W'(1));
								rem_q     <= total_q - CNT_W'(1) - {1'b0, idx_s1};
							end else begin
								w0_q     <= '{offset: ent_rd.offset, payload: ent_rd.payload,
									in_use: 1'b1};
								tot_nx_q <= total_q;
								rem_q    <= '0;
							end
						end
					end else if (v_s1) begin
						prev_q <= ent_rd;
					end else if (miss) begin
						res_addr_q <= '0;
						res_st_q   <= mode_q ? ST_UNKNOWN : ST_NO_MEMORY;
						state_q    <= S_DONE;
					end
				end
				S_NEXT: begin
					// The right neighbour is on the read port now; merge with free
					// neighbours and close up the table behind the merged block.
					up_q    <= 1'b0;
					state_q <= S_SHIFT;
					if (prev_free && next_free) begin
						w0_addr_q <= k_q - IDX_W'(1);
						w0_q      <= '{offset: prev_q.offset, payload: prev_q.payload + HDR16
							+ hit_q.payload + HDR16 + ent_rd.payload, in_use: 1'b0};
						two_q     <= 1'b1;
						src_q     <= k_q + IDX_W'(2);
						rem_q     <= total_q - {1'b0, k_q} - CNT_W'(2);
						tot_nx_q  <= total_q - CNT_W'(2);
					end else if (prev_free) begin
						w0_addr_q <= k_q - IDX_W'(1);
						w0_q      <= '{offset: prev_q.offset,
							payload: prev_q.payload + HDR16 + hit_q.payload, in_use: 1'b0};
						two_q     <= 1'b0;
						src_q     <= k_q + IDX_W'(1);
						rem_q     <= total_q - {1'b0, k_q} - CNT_W'(1);
						tot_nx_q  <= total_q - CNT_W'(1);
					end else if (next_free) begin
						w0_addr_q <= k_q;
						w0_q      <= '{offset: hit_q.offset,
							payload: hit_q.payload + HDR16 + ent_rd.payload, in_use: 1'b0};
						two_q     <= 1'b0;
						src_q     <= k_q + IDX_W'(2);
						rem_q     <= total_q - {1'b0, k_q} - CNT_W'(2);
						tot_nx_q  <= total_q - CNT_W'(1);
					end else begin
						w0_addr_q <= k_q;
						w0_q      <= '{offset: hit_q.offset, payload: hit_q.payload,
							in_use: 1'b0};
						rem_q     <= '0;
						tot_nx_q  <= total_q;
					end
				end
				S_SHIFT: begin
					sv_s1 <= (rem_q != '0);
					if (rem_q != '0) begin
						rem_q  <= rem_q - CNT_W'(1);
						if (up_q) begin
							dst_s1 <= src_q + IDX_W'(1);
							src_q  <= src_q - IDX_W'(1);
						end else begin
							dst_s1 <= two_q ? (src_q - IDX_W'(2)) : (src_q - IDX_W'(1));
							src_q  <= src_q + IDX_W'(1);
						end
					end else if (!sv_s1) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (w1_en_q) begin
						w1_en_q <= 1'b0;
					end else begin
						total_q <= tot_nx_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_addr_q  <= res_addr_q;
						out_st_q    <= res_st_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`FFHA_ASSERT_ALWAYS(a_total_range, (total_q != '0) && (total_q <= CNT_W'(MAX_BLOCKS)),
		"block count out of range")
	`FFHA_ASSERT_SAME(a_write_bound, ram_we,
		({1'b0, ram_waddr} <= total_q), "table write beyond the last entry")
	`FFHA_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_q != S_IDLE,
		"request transfer did not start work")
	`FFHA_ASSERT_NEXT(a_done_holds, (state_q == S_DONE) && out_valid_q && !out_ready,
		state_q == S_DONE, "finished result dropped while output stalled")

endmodule
